// ----- hdl/sha512_hash_engine_macros.svh -----
// assertion macros for the sha-512 hash engine
// no dependencies; included by the top level only
`ifndef SHA512_HASH_ENGINE_MACROS_SVH
`define SHA512_HASH_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHA_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- hdl/sha512_pkg.sv -----
// shared types and constants of the sha-512 hash engine
// no dependencies
package sha512_pkg;

    typedef struct packed {
        logic              fin_blk;
        logic [15:0][63:0] blk;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [63:0] iv_word(input logic [2:0] idx);
        logic [63:0] r;
        case (idx)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            3'd7: r = 64'h5be0cd19137e2179;
            default: r = 64'h0;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] k_word(input logic [6:0] idx);
        logic [63:0] r;
        case (idx)
            7'd0:  r = 64'h428a2f98d728ae22;
            7'd1:  r = 64'h7137449123ef65cd;
            7'd2:  r = 64'hb5c0fbcfec4d3b2f;
            7'd3:  r = 64'he9b5dba58189dbbc;
            7'd4:  r = 64'h3956c25bf348b538;
            7'd5:  r = 64'h59f111f1b605d019;
            7'd6:  r = 64'h923f82a4af194f9b;
            7'd7:  r = 64'hab1c5ed5da6d8118;
            7'd8:  r = 64'hd807aa98a3030242;
            7'd9:  r = 64'h12835b0145706fbe;
            7'd10: r = 64'h243185be4ee4b28c;
            7'd11: r = 64'h550c7dc3d5ffb4e2;
            7'd12: r = 64'h72be5d74f27b896f;
            7'd13: r = 64'h80deb1fe3b1696b1;
            7'd14: r = 64'h9bdc06a725c71235;
            7'd15: r = 64'hc19bf174cf692694;
            7'd16: r = 64'he49b69c19ef14ad2;
            7'd17: r = 64'hefbe4786384f25e3;
            7'd18: r = 64'h0fc19dc68b8cd5b5;
            7'd19: r = 64'h240ca1cc77ac9c65;
            7'd20: r = 64'h2de92c6f592b0275;
            7'd21: r = 64'h4a7484aa6ea6e483;
            7'd22: r = 64'h5cb0a9dcbd41fbd4;
            7'd23: r = 64'h76f988da831153b5;
            7'd24: r = 64'h983e5152ee66dfab;
            7'd25: r = 64'ha831c66d2db43210;
            7'd26: r = 64'hb00327c898fb213f;
            7'd27: r = 64'hbf597fc7beef0ee4;
            7'd28: r = 64'hc6e00bf33da88fc2;
            7'd29: r = 64'hd5a79147930aa725;
            7'd30: r = 64'h06ca6351e003826f;
            7'd31: r = 64'h142929670a0e6e70;
            7'd32: r = 64'h27b70a8546d22ffc;
            7'd33: r = 64'h2e1b21385c26c926;
            7'd34: r = 64'h4d2c6dfc5ac42aed;
            7'd35: r = 64'h53380d139d95b3df;
            7'd36: r = 64'h650a73548baf63de;
            7'd37: r = 64'h766a0abb3c77b2a8;
            7'd38: r = 64'h81c2c92e47edaee6;
            7'd39: r = 64'h92722c851482353b;
            7'd40: r = 64'ha2bfe8a14cf10364;
            7'd41: r = 64'ha81a664bbc423001;
            7'd42: r = 64'hc24b8b70d0f89791;
            7'd43: r = 64'hc76c51a30654be30;
            7'd44: r = 64'hd192e819d6ef5218;
            7'd45: r = 64'hd69906245565a910;
            7'd46: r = 64'hf40e35855771202a;
            7'd47: r = 64'h106aa07032bbd1b8;
            7'd48: r = 64'h19a4c116b8d2d0c8;
            7'd49: r = 64'h1e376c085141ab53;
            7'd50: r = 64'h2748774cdf8eeb99;
            7'd51: r = 64'h34b0bcb5e19b48a8;
            7'd52: r = 64'h391c0cb3c5c95a63;
            7'd53: r = 64'h4ed8aa4ae3418acb;
            7'd54: r = 64'h5b9cca4f7763e373;
            7'd55: r = 64'h682e6ff3d6b2b8a3;
            7'd56: r = 64'h748f82ee5defb2fc;
            7'd57: r = 64'h78a5636f43172f60;
            7'd58: r = 64'h84c87814a1f0ab72;
            7'd59: r = 64'h8cc702081a6439ec;
            7'd60: r = 64'h90befffa23631e28;
            7'd61: r = 64'ha4506cebde82bde9;
            7'd62: r = 64'hbef9a3f7b2c67915;
            7'd63: r = 64'hc67178f2e372532b;
            7'd64: r = 64'hca273eceea26619c;
            7'd65: r = 64'hd186b8c721c0c207;
            7'd66: r = 64'heada7dd6cde0eb1e;
            7'd67: r = 64'hf57d4f7fee6ed178;
            7'd68: r = 64'h06f067aa72176fba;
            7'd69: r = 64'h0a637dc5a2c898a6;
            7'd70: r = 64'h113f9804bef90dae;
            7'd71: r = 64'h1b710b35131c471b;
            7'd72: r = 64'h28db77f523047d84;
            7'd73: r = 64'h32caab7b40c72493;
            7'd74: r = 64'h3c9ebe0a15c9bebc;
            7'd75: r = 64'h431d67c49c100d4c;
            7'd76: r = 64'h4cc5d4becb3e42b6;
            7'd77: r = 64'h597f299cfc657e2a;
            7'd78: r = 64'h5fcb6fab3ad6faec;
            7'd79: r = 64'h6c44198c4a475817;
            default: r = 64'h0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/sha512_front.sv -----
// byte packing and padding front end of the sha-512 hash engine
// depends on sha512_pkg
module sha512_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [63:0]         i_data_word,
    input  logic [3:0]          i_bytes_valid,
    input  logic                i_last_of_message,
    output logic                o_job_push,
    output sha512_pkg::t_job    o_job,
    input  sha512_pkg::t_q_stat i_q_stat
);
    import sha512_pkg::*;

    localparam logic [1:0] ST_ACC = 2'd0;
    localparam logic [1:0] ST_PAD = 2'd1;
    localparam logic [1:0] ST_LEN = 2'd2;

    logic [1:0]        r_state;
    logic [6:0]        r_fill;
    logic [60:0]       r_count;
    logic [63:0]       r_part;
    logic [15:0][63:0] r_buf;

    logic [3:0]   nb;
    logic [63:0]  mask;
    logic [127:0] sh;
    logic [63:0]  hi;
    logic [63:0]  lo;
    logic [7:0]   sum;
    logic [3:0]   idx;
    logic [2:0]   off;
    logic         acc;
    logic [63:0]  padw;
    logic [63:0]  bits;
    logic         ovf;

    always_comb begin
        nb   = (i_bytes_valid > 4'd8) ? 4'd8 : i_bytes_valid;
        mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> {nb, 3'b000});
        idx  = r_fill[6:3];
        off  = r_fill[2:0];
        sh   = {i_data_word & mask, 64'h0} >> {off, 3'b000};
        hi   = sh[127:64];
        lo   = sh[63:0];
        sum  = {1'b0, r_fill} + {4'b0000, nb};
        padw = r_part | ({8'h80, 56'h0} >> {off, 3'b000});
        bits = {r_count, 3'b000};
        ovf  = (r_fill[6:4] == 3'b111);
        o_full = (r_state != ST_ACC) || i_q_stat.full;
        acc    = i_push && !o_full;
    end

    // block handed to the compression side
    always_comb begin
        o_job_push    = 1'b0;
        o_job.fin_blk = 1'b0;
        o_job.blk     = r_buf;
        case (r_state)
            ST_ACC: begin
                o_job.blk[idx] = r_part | hi;
                o_job_push     = acc && sum[7];
            end
            ST_PAD: begin
                o_job.blk[idx] = padw;
                if (!ovf) begin
                    o_job.blk[15]  = bits;
                    o_job.fin_blk  = 1'b1;
                end
                o_job_push = !i_q_stat.full;
            end
            ST_LEN: begin
                o_job.blk      = '0;
                o_job.blk[15]  = bits;
                o_job.fin_blk  = 1'b1;
                o_job_push     = !i_q_stat.full;
            end
            default: begin
                o_job_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_ACC;
            r_fill  <= '0;
            r_count <= '0;
            r_part  <= '0;
            r_buf   <= '0;
        end else begin
            case (r_state)
                ST_ACC: begin
                    if (acc) begin
                        r_count <= r_count + 61'(nb);
                        r_fill  <= sum[6:0];
                        if (sum[7]) begin
                            r_buf    <= '0;
                            r_buf[0] <= lo;
                            r_part   <= lo;
                        end else if (sum[6:3] != idx) begin
                            r_buf[idx]      <= r_part | hi;
                            r_buf[sum[6:3]] <= lo;
                            r_part          <= lo;
                        end else begin
                            r_part <= r_part | hi;
                        end
                        if (i_last_of_message) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    if (!i_q_stat.full) begin
                        r_buf  <= '0;
                        r_part <= '0;
                        if (ovf) begin
                            r_state <= ST_LEN;
                        end else begin
                            r_fill  <= '0;
                            r_count <= '0;
                            r_state <= ST_ACC;
                        end
                    end
                end
                ST_LEN: begin
                    if (!i_q_stat.full) begin
                        r_fill  <= '0;
                        r_count <= '0;
                        r_state <= ST_ACC;
                    end
                end
                default: begin
                    r_state <= ST_ACC;
                end
            endcase
        end
    end

endmodule

// ----- hdl/sha512_jobq.sv -----
// two-entry block queue between front end and compression core
// depends on sha512_pkg
module sha512_jobq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  sha512_pkg::t_job    i_job,
    input  logic                i_rd,
    output sha512_pkg::t_job    o_job,
    output sha512_pkg::t_q_stat o_stat
);
    import sha512_pkg::*;

    t_job       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic wr_ok;
    logic rd_ok;

    always_comb begin
        o_stat.full  = (r_cnt == 2'd2);
        o_stat.empty = (r_cnt == 2'd0);
        wr_ok        = i_wr && !o_stat.full;
        rd_ok        = i_rd && !o_stat.empty;
        o_job        = r_ent[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_ent[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= !r_wp;
            end
            if (rd_ok) begin
                r_rp <= !r_rp;
            end
            case ({wr_ok, rd_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/sha512_core.sv -----
// 80-round compression core with chaining value and digest output register
// depends on sha512_pkg
module sha512_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha512_pkg::t_job    i_job,
    input  sha512_pkg::t_q_stat i_q_stat,
    output logic                o_job_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [63:0]         o_digest_word,
    output logic [2:0]          o_word_index,
    output logic                o_last_word
);
    import sha512_pkg::*;

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_FIN  = 2'd2;

    logic [1:0]        r_state;
    logic [6:0]        r_t;
    logic              r_fin;
    logic [7:0][63:0]  r_chain;
    logic [7:0][63:0]  r_v;
    logic [15:0][63:0] r_w;
    logic [7:0][63:0]  r_dig;
    logic [2:0]        r_oidx;
    logic              r_ovalid;

    logic [63:0]      t1;
    logic [63:0]      t2;
    logic [63:0]      nw;
    logic [7:0][63:0] sums;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    always_comb begin
        t1 = r_v[7] + (rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41))
             + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + k_word(r_t) + r_w[0];
        t2 = (rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        nw = (rotr(r_w[14], 19) ^ rotr(r_w[14], 61) ^ (r_w[14] >> 6)) + r_w[9]
             + (rotr(r_w[1], 1) ^ rotr(r_w[1], 8) ^ (r_w[1] >> 7)) + r_w[0];
        for (int i = 0; i < 8; i++) begin
            sums[i] = r_chain[i] + r_v[i];
        end
        o_job_pop     = (r_state == C_IDLE) && !i_q_stat.empty;
        o_empty       = !r_ovalid;
        o_digest_word = r_dig[r_oidx];
        o_word_index  = r_oidx;
        o_last_word   = (r_oidx == 3'd7);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            C_IDLE: begin
                if (o_job_pop) begin
                    r_w   <= i_job.blk;
                    r_v   <= r_chain;
                    r_fin <= i_job.fin_blk;
                end
            end
            C_RUN: begin
                r_w[14:0] <= r_w[15:1];
                r_w[15]   <= nw;
                r_v[7]    <= r_v[6];
                r_v[6]    <= r_v[5];
                r_v[5]    <= r_v[4];
                r_v[4]    <= r_v[3] + t1;
                r_v[3]    <= r_v[2];
                r_v[2]    <= r_v[1];
                r_v[1]    <= r_v[0];
                r_v[0]    <= t1 + t2;
            end
            default: begin
                if (r_fin && !r_ovalid) begin
                    r_dig <= sums;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= C_IDLE;
            r_t      <= '0;
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= iv_word(3'(i));
            end
        end else begin
            if (r_ovalid && i_pop) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    r_ovalid <= 1'b0;
                end
            end
            case (r_state)
                C_IDLE: begin
                    if (o_job_pop) begin
                        r_t     <= '0;
                        r_state <= C_RUN;
                    end
                end
                C_RUN: begin
                    r_t <= r_t + 7'd1;
                    if (r_t == 7'd79) begin
                        r_state <= C_FIN;
                    end
                end
                C_FIN: begin
                    if (!r_fin) begin
                        r_chain <= sums;
                        r_state <= C_IDLE;
                    end else if (!r_ovalid) begin
                        for (int i = 0; i < 8; i++) begin
                            r_chain[i] <= iv_word(3'(i));
                        end
                        r_ovalid <= 1'b1;
                        r_oidx   <= '0;
                        r_state  <= C_IDLE;
                    end
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hdl/sha512_hash_engine.sv -----
// sha-512 hash engine top: front end, block queue and compression core
// input transfers are accepted while the block queue has room; a last item then holds full
// through the padding state, and through a length state when the length needs an extra block
// the compression core takes each block through a load step, the rounds and the chain update
// digest: 8 output transfers; the final block's sums are registered once the previous digest is fully transferred
// synchronous active-low reset restores the initial hash value and empties every queue
// depends on sha512_pkg, sha512_front, sha512_jobq, sha512_core and the macro header
`include "sha512_hash_engine_macros.svh"
module sha512_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_bytes_valid,
    input  logic        i_last_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha512_pkg::*;

    // front to queue
    logic    job_push;
    t_job    job_in;
    // queue to core
    t_job    job_head;
    t_q_stat q_stat;
    logic    job_pop;

    // front end packs bytes into 128-byte blocks, appends padding and length
    sha512_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_data_word       (i_data_word),
        .i_bytes_valid     (i_bytes_valid),
        .i_last_of_message (i_last_of_message),
        .o_job_push        (job_push),
        .o_job             (job_in),
        .i_q_stat          (q_stat)
    );

    // two blocks of slack so input transfers continue during compression
    sha512_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_push),
        .i_job   (job_in),
        .i_rd    (job_pop),
        .o_job   (job_head),
        .o_stat  (q_stat)
    );

    // one round per cycle, digest held until all eight words are transferred
    sha512_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (job_head),
        .i_q_stat      (q_stat),
        .o_job_pop     (job_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    // the front end never pushes a block into a full queue
    `SHA_NEVER(a_no_overflow, i_clk, i_rst_n, (q_stat.full && job_push), "block queue overflow")
    // after the final digest word is transferred the output goes empty
    `SHA_ASSERT(a_digest_end, i_clk, i_rst_n, (!empty && pop && o_last_word) |=> empty, "digest not closed")
    // a transferred word that is not the last is followed by the next index
    `SHA_ASSERT(a_digest_seq, i_clk, i_rst_n, (!empty && pop && !o_last_word) |=> (!empty && (o_word_index == $past(o_word_index) + 3'd1)), "digest word order broken")

endmodule

// ----- test/sha512_checker.sv -----
// checker for the sha-512 hash engine: watches both queue sides, predicts digests, compares
// depends on nothing but the port widths of sha512_hash_engine
module sha512_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_bytes_valid,
    input  logic        i_last_of_message,
    input  logic        empty,
    input  logic        pop,
    input  logic [63:0] o_digest_word,
    input  logic [2:0]  o_word_index,
    input  logic        o_last_word,
    output int          o_fail_count,
    output int          o_digest_count,
    output int          o_pending
);
    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_out;

    localparam logic [63:0] HASH_IV [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

    logic [63:0] hash_state [8];
    logic [7:0]  msg_block [128];
    int unsigned block_fill;
    logic [60:0] msg_len_bytes;
    t_digest_out digest_q [$];
    int fails;
    int digests;

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) hash_state[i] = HASH_IV[i];
        for (int i = 0; i < 128; i++) msg_block[i] = 8'h00;
        block_fill = 0;
        msg_len_bytes = '0;
    endtask

    task automatic compress_block();
        logic [63:0] w [16];
        logic [63:0] v [8];
        logic [63:0] wt, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            for (int b = 0; b < 8; b++) w[i] = {w[i][55:0], msg_block[i*8+b]};
        for (int i = 0; i < 8; i++) v[i] = hash_state[i];
        for (int t = 0; t < 80; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                s1 = ror64(w[14], 19) ^ ror64(w[14], 61) ^ (w[14] >> 6);
                s0 = ror64(w[1], 1) ^ ror64(w[1], 8) ^ (w[1] >> 7);
                wt = s1 + w[9] + s0 + w[0];
                for (int i = 0; i < 15; i++) w[i] = w[i+1];
                w[15] = wt;
            end
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + wt;
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int i = 7; i > 0; i--) v[i] = v[i-1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
        for (int i = 0; i < 128; i++) msg_block[i] = 8'h00;
    endtask

    task automatic absorb_word(input logic [63:0] data, input logic [3:0] nbytes,
                               input logic fin);
        int cnt;
        logic [63:0] bits;
        t_digest_out d;
        cnt = (nbytes > 8) ? 8 : nbytes;
        for (int i = 0; i < cnt; i++) begin
            msg_block[block_fill] = data[63-8*i -: 8];
            block_fill++;
            if (block_fill == 128) begin
                compress_block();
                block_fill = 0;
            end
        end
        msg_len_bytes += cnt;
        if (fin) begin
            // pad byte, then an extra block when the length does not fit
            msg_block[block_fill] = 8'h80;
            block_fill++;
            if (128 - block_fill < 16) compress_block();
            bits = {msg_len_bytes, 3'b000};
            for (int i = 0; i < 8; i++) msg_block[127-i] = bits[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++) begin
                d.word = hash_state[i];
                d.index = i[2:0];
                d.last = (i == 7);
                digest_q.push_back(d);
            end
            restart_hash();
        end
    endtask

    initial begin
        fails = 0;
        digests = 0;
        restart_hash();
    end

    always @(posedge i_clk) begin
        t_digest_out exp_d;
        if (!i_rst_n) begin
            restart_hash();
            digest_q.delete();
        end else begin
            if (pop && !empty) begin
                if (digest_q.size() == 0) begin
                    $error("unexpected digest transfer word=%h", o_digest_word);
                    fails++;
                end else begin
                    exp_d = digest_q.pop_front();
                    digests++;
                    if (o_digest_word !== exp_d.word) begin
                        $error("digest_word expected %h actual %h", exp_d.word, o_digest_word);
                        fails++;
                    end
                    if (o_word_index !== exp_d.index) begin
                        $error("word_index expected %0d actual %0d", exp_d.index, o_word_index);
                        fails++;
                    end
                    if (o_last_word !== exp_d.last) begin
                        $error("last_word expected %0d actual %0d", exp_d.last, o_last_word);
                        fails++;
                    end
                end
            end
            if (push && !full) absorb_word(i_data_word, i_bytes_valid, i_last_of_message);
        end
    end

    assign o_fail_count = fails;
    assign o_digest_count = digests;
    assign o_pending = digest_q.size();
endmodule

// ----- test/tb.sv -----
// top of the sha-512 hash engine testbench: clock, reset, stimulus, stall and verdict
// depends on sha512_hash_engine and sha512_checker
module tb;
    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [63:0] i_data_word;
    logic [3:0]  i_bytes_valid;
    logic        i_last_of_message;
    logic        empty;
    logic        pop;
    logic [63:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;
    int          fail_count;
    int          digest_count;
    int          pending;
    int          words_sent;
    int          messages;
    int          idle_cycles;
    int          msg_words;
    logic        steady;      // long stretch with no idling on either side
    logic        timed_out;

    localparam int WATCHDOG_LIMIT = 20000;

    sha512_hash_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_data_word(i_data_word), .i_bytes_valid(i_bytes_valid),
        .i_last_of_message(i_last_of_message), .empty(empty), .pop(pop),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    sha512_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_data_word(i_data_word), .i_bytes_valid(i_bytes_valid),
        .i_last_of_message(i_last_of_message), .empty(empty), .pop(pop),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word), .o_fail_count(fail_count),
        .o_digest_count(digest_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // result side: random pop stalls, none during the steady stretch
    initial pop = 1'b0;
    always @(posedge i_clk) begin
        pop <= steady ? 1'b1 : ($urandom_range(99) >= 37);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one input transfer; push held until accepted, random idle cycles before it
    // push stays high after the transfer until an idle cycle of the next call or the end of stimulus drops it
    task automatic send_word(input logic [63:0] data, input logic [3:0] nbytes,
                             input logic fin);
        while (!steady && $urandom_range(99) < 37) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_data_word <= data;
        i_bytes_valid <= nbytes;
        i_last_of_message <= fin;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        words_sent++;
        if (fin) messages++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // message of nwords random words; byte counts mostly full, ends with a last word
    task automatic send_message(input int nwords);
        logic [3:0] nb;
        for (int i = 0; i < nwords; i++) begin
            case ($urandom_range(9))
                0: nb = 4'($urandom_range(15));
                1: nb = 4'($urandom_range(8));
                default: nb = 4'd8;
            endcase
            send_word(rand64(), nb, i == nwords - 1);
        end
    endtask

    initial begin
        timed_out = 1'b0;
        steady = 1'b0;
        words_sent = 0;
        messages = 0;
        idle_cycles = 0;
        msg_words = 0;
        push = 1'b0;
        i_data_word = '0;
        i_bytes_valid = '0;
        i_last_of_message = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, the classic "abc", field extremes
        send_word(64'h0, 4'd0, 1'b1);
        send_word(64'h6162630000000000, 4'd3, 1'b1);
        send_word(64'hffffffffffffffff, 4'd15, 1'b0);   // count above eight taken as eight
        send_word(64'h0123456789abcdef, 4'd0, 1'b0);    // empty, not last
        send_word(64'hffffffffffffffff, 4'd8, 1'b1);
        send_word(64'h0000000000000000, 4'd8, 1'b1);
        // 15 full words + 7 bytes: pad lands at byte 127, extra block needed
        for (int i = 0; i < 15; i++) send_word(rand64(), 4'd8, 1'b0);
        send_word(64'haaaaaaaaaaaaaaaa, 4'd7, 1'b1);

        // random messages; sizes mostly short, a few crossing several blocks
        while (words_sent < 330) begin
            if (words_sent > 120 && words_sent < 200) steady = 1'b1;
            else steady = 1'b0;
            if ($urandom_range(9) == 0) msg_words = $urandom_range(17, 40);
            else msg_words = $urandom_range(1, 18);
            if (msg_words > 330 - words_sent) msg_words = 330 - words_sent;
            send_message(msg_words);
        end
        steady = 1'b0;
        push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d words in %0d messages, checked %0d digest words",
                 words_sent, messages, digest_count);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
